// ===== sv/bfm_pkg.sv =====
// Package for the Bloom filter with MurmurHash3 x64_128 probing.
// Holds hash constants, geometry constants, the operation and state codes and shared types.
// No dependencies.
package bfm_pkg;

  localparam int unsigned FILTER_BITS_DEF = 8192;

  localparam int unsigned NUM_PROBES = 4;
  localparam int unsigned PROBE_W    = $clog2(NUM_PROBES);
  localparam int unsigned WORD_W     = 32;

  localparam int unsigned ROW_W  = 32;
  localparam int unsigned ROW_BW = $clog2(ROW_W);

  localparam int unsigned HASH_STAGES = 12;
  localparam int unsigned MOD_STEP    = 4;
  localparam int unsigned MOD_STAGES  = WORD_W / MOD_STEP;
  localparam int unsigned PIPE_STAGES = HASH_STAGES + MOD_STAGES;

  localparam logic [63:0] MM_SEED = 64'd1;
  localparam logic [63:0] MM_LEN  = 64'd8;
  localparam logic [63:0] MM_MIX  = MM_SEED ^ MM_LEN;
  localparam logic [63:0] MM_C1   = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2   = 64'h4cf5ad432745937f;
  localparam logic [63:0] MM_F1   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MM_F2   = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_QUERY  = 2'd1,
    FN_CLEAR  = 2'd2
  } bfm_func_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_PROBE,
    ST_CLEAR
  } bfm_state_e;

  typedef struct packed {
    logic      valid;
    bfm_func_e func;
  } bfm_op_t;

  function automatic logic [63:0] xs33(logic [63:0] x);
    return x ^ (x >> 33);
  endfunction

  function automatic logic [63:0] rotl31(logic [63:0] x);
    return {x[32:0], x[63:33]};
  endfunction

endpackage

// ===== sv/bfm_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// Read-first on a same-address collision. No dependencies.
module bfm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bfm_mul64.sv =====
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
// Built from three 32x32 partial products. No dependencies.
module bfm_mul64 (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] lo_q;
  logic [31:0] x1_q, x2_q;
  logic [63:0] p_q;
  logic [63:0] lo_d;
  logic [31:0] x1_d, x2_d;

  always_comb begin
    lo_d = 64'(a_i[31:0]) * 64'(b_i[31:0]);
    x1_d = a_i[31:0] * b_i[63:32];
    x2_d = a_i[63:32] * b_i[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= lo_d;
      x1_q <= x1_d;
      x2_q <= x2_d;
      p_q  <= lo_q + {x1_q + x2_q, 32'd0};
    end
  end

  assign p_o = p_q;

endmodule

// ===== sv/bfm_hash.sv =====
// Stalling pipeline: MurmurHash3 x64_128 of one 64-bit key, then four words reduced
// modulo the filter size. Depends on bfm_pkg and bfm_mul64.
module bfm_hash import bfm_pkg::*; #(
  parameter int unsigned FilterBits = FILTER_BITS_DEF,
  localparam int unsigned IdxW = $clog2(FilterBits)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_vld_i,
  input  logic [1:0]                       func_i,
  input  logic [63:0]                      key_i,
  output logic                             en_o,
  output bfm_op_t                          op_o,
  output logic [NUM_PROBES-1:0][IdxW-1:0]  idx_o,
  input  logic                             take_i
);

  localparam logic [IdxW:0] FbW = (IdxW+1)'(FilterBits);

  logic en;
  bfm_op_t [PIPE_STAGES-1:0] op_q;

  logic [63:0] ka, kb, m1a, m2a, m1b, m2b;
  logic [63:0] h1a_q, h1b_q, h2b_q, g1_q, g2_q;
  logic [NUM_PROBES-1:0][WORD_W-1:0] w_q;

  logic [MOD_STAGES-1:0][NUM_PROBES-1:0][IdxW-1:0]   rem_q, rem_d;
  logic [MOD_STAGES-2:0][NUM_PROBES-1:0][WORD_W-1:0] wrd_q, wrd_d;

  function automatic logic [IdxW-1:0] mod_step(logic [IdxW-1:0] r_in,
                                               logic [MOD_STEP-1:0] bits);
    logic [IdxW:0]   t;
    logic [IdxW-1:0] r;
    r = r_in;
    for (int s = MOD_STEP - 1; s >= 0; s--) begin
      t = {r, bits[s]};
      if (t >= FbW) begin
        t = t - FbW;
      end
      r = t[IdxW-1:0];
    end
    return r;
  endfunction

  assign en = !op_q[PIPE_STAGES-1].valid || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= '0;
    end else if (en) begin
      op_q <= {op_q[PIPE_STAGES-2:0], {in_vld_i, bfm_func_e'(func_i)}};
    end
  end

  bfm_mul64 u_mul_c1 (.clk_i, .en_i(en), .a_i(key_i),        .b_i(MM_C1), .p_o(ka));
  bfm_mul64 u_mul_c2 (.clk_i, .en_i(en), .a_i(rotl31(ka)),   .b_i(MM_C2), .p_o(kb));
  bfm_mul64 u_mul_f1a (.clk_i, .en_i(en), .a_i(xs33(h1b_q)), .b_i(MM_F1), .p_o(m1a));
  bfm_mul64 u_mul_f1b (.clk_i, .en_i(en), .a_i(xs33(h2b_q)), .b_i(MM_F1), .p_o(m2a));
  bfm_mul64 u_mul_f2a (.clk_i, .en_i(en), .a_i(xs33(m1a)),   .b_i(MM_F2), .p_o(m1b));
  bfm_mul64 u_mul_f2b (.clk_i, .en_i(en), .a_i(xs33(m2a)),   .b_i(MM_F2), .p_o(m2b));

  always_ff @(posedge clk_i) begin
    if (en) begin
      h1a_q <= (kb ^ MM_MIX) + MM_MIX;
      h1b_q <= h1a_q;
      h2b_q <= h1a_q + MM_MIX;
      g1_q  <= xs33(m1b) + xs33(m2b);
      g2_q  <= xs33(m2b);
      w_q   <= {g2_q + g1_q, g1_q};
      rem_q <= rem_d;
      wrd_q <= wrd_d;
    end
  end

  // Restoring remainder, MOD_STEP bits per stage, MSB first
  always_comb begin
    for (int l = 0; l < NUM_PROBES; l++) begin
      rem_d[0][l] = mod_step('0, w_q[l][WORD_W-1 -: MOD_STEP]);
    end
    wrd_d[0] = w_q;
    for (int m = 1; m < MOD_STAGES; m++) begin
      for (int l = 0; l < NUM_PROBES; l++) begin
        rem_d[m][l] = mod_step(rem_q[m-1][l],
                               wrd_q[m-1][l][WORD_W-1-MOD_STEP*m -: MOD_STEP]);
      end
    end
    for (int m = 1; m < MOD_STAGES - 1; m++) begin
      wrd_d[m] = wrd_q[m-1];
    end
  end

  assign en_o  = en;
  assign op_o  = op_q[PIPE_STAGES-1];
  assign idx_o = rem_q[MOD_STAGES-1];

endmodule

// ===== sv/bfm_probe.sv =====
// Probe engine: reads the four filter bits per key in a row-organized bit memory and
// sets them on insert; clear sweeps; result register. Depends on bfm_pkg and bfm_ram.
module bfm_probe import bfm_pkg::*; #(
  parameter int unsigned FilterBits = FILTER_BITS_DEF,
  localparam int unsigned IdxW = $clog2(FilterBits)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bfm_op_t                          op_i,
  input  logic [NUM_PROBES-1:0][IdxW-1:0]  idx_i,
  output logic                             take_o,
  output logic                             busy_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             maybe_present_o
);

  localparam int unsigned Rows  = (FilterBits + ROW_W - 1) / ROW_W;
  localparam int unsigned AddrW = $clog2(Rows);
  localparam logic [AddrW-1:0]   LastRow   = AddrW'(Rows - 1);
  localparam logic [PROBE_W-1:0] LastProbe = PROBE_W'(NUM_PROBES - 1);

  bfm_state_e state_q, state_d;
  logic [AddrW-1:0]   cnt_q, cnt_d;
  logic [PROBE_W-1:0] p_q, p_d;
  logic cur_ins_q, cur_ins_d;
  logic [NUM_PROBES-1:0][IdxW-1:0] cur_idx_q, cur_idx_d;

  logic resp_v_q, resp_last_q, resp_first_q, resp_ins_q;
  logic [AddrW-1:0]  resp_row_q;
  logic [ROW_BW-1:0] resp_bit_q;
  logic hit_q;

  logic fwd_v_q;
  logic [AddrW-1:0] fwd_addr_q;
  logic [ROW_W-1:0] fwd_data_q;

  logic out_valid_q, out_valid_d, maybe_q, maybe_d;

  logic take, issue, clr_we, probe_we, done_now;
  logic out_free, hit_now, is_probe_op;
  logic [IdxW-1:0]   cur_idx;
  logic [AddrW-1:0]  raddr, waddr;
  logic [ROW_W-1:0]  rdata, row_cur, set_row, wdata;
  logic we;

  bfm_ram #(.Width(ROW_W), .Depth(Rows)) u_ram (
    .clk_i,
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_free    = !out_valid_q || out_ready_i;
  assign is_probe_op = op_i.func inside {FN_INSERT, FN_QUERY};
  assign cur_idx     = cur_idx_q[p_q];
  assign raddr       = AddrW'(cur_idx >> ROW_BW);

  // Last write is not yet visible to a read issued on the same edge
  assign row_cur  = (fwd_v_q && fwd_addr_q == resp_row_q) ? fwd_data_q : rdata;
  assign hit_now  = (resp_first_q || hit_q) && row_cur[resp_bit_q];
  assign set_row  = row_cur | (ROW_W'(1) << resp_bit_q);
  assign probe_we = resp_v_q && resp_ins_q;

  assign we    = clr_we || probe_we;
  assign waddr = clr_we ? cnt_q : resp_row_q;
  assign wdata = clr_we ? '0 : set_row;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    p_d       = p_q;
    cur_ins_d = cur_ins_q;
    cur_idx_d = cur_idx_q;
    take      = 1'b0;
    issue     = 1'b0;
    clr_we    = 1'b0;
    done_now  = 1'b0;

    case (state_q)
      ST_INIT: begin
        clr_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == LastRow) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (op_i.valid) begin
          case (op_i.func)
            FN_INSERT, FN_QUERY: begin
              take    = 1'b1;
              state_d = ST_PROBE;
              p_d     = '0;
            end
            FN_CLEAR: begin
              if (!resp_v_q) begin
                take    = 1'b1;
                state_d = ST_CLEAR;
                cnt_d   = '0;
              end
            end
            default: begin
              if (!resp_v_q && out_free) begin
                take     = 1'b1;
                done_now = 1'b1;
              end
            end
          endcase
        end
      end
      ST_PROBE: begin
        if (p_q != LastProbe || out_free) begin
          issue = 1'b1;
          p_d   = p_q + 1'b1;
          if (p_q == LastProbe) begin
            if (op_i.valid && is_probe_op) begin
              take = 1'b1;
              p_d  = '0;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_CLEAR: begin
        clr_we = 1'b1;
        if (cnt_q == LastRow) begin
          if (out_free) begin
            done_now = 1'b1;
            cnt_d    = '0;
            state_d  = ST_IDLE;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_INIT;
        cnt_d   = '0;
      end
    endcase

    if (take) begin
      cur_ins_d = (op_i.func == FN_INSERT);
      cur_idx_d = idx_i;
    end

    out_valid_d = out_valid_q && !out_ready_i;
    maybe_d     = maybe_q;
    if (resp_v_q && resp_last_q) begin
      out_valid_d = 1'b1;
      maybe_d     = !resp_ins_q && hit_now;
    end else if (done_now) begin
      out_valid_d = 1'b1;
      maybe_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      p_q         <= '0;
      resp_v_q    <= 1'b0;
      fwd_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      p_q         <= p_d;
      resp_v_q    <= issue;
      fwd_v_q     <= probe_we;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_ins_q    <= cur_ins_d;
    cur_idx_q    <= cur_idx_d;
    resp_last_q  <= (p_q == LastProbe);
    resp_first_q <= (p_q == '0);
    resp_ins_q   <= cur_ins_q;
    resp_row_q   <= raddr;
    resp_bit_q   <= cur_idx[ROW_BW-1:0];
    fwd_addr_q   <= resp_row_q;
    fwd_data_q   <= set_row;
    maybe_q      <= maybe_d;
    if (resp_v_q) begin
      hit_q <= hit_now;
    end
  end

  assign take_o          = take;
  assign busy_o          = (state_q == ST_INIT);
  assign out_valid_o     = out_valid_q;
  assign maybe_present_o = maybe_q;

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resp_v_q && resp_last_q) |-> out_free)
    else $error("result completes while previous result is pending");

  a_sweep_writes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT || state_q == ST_CLEAR) |-> (we && wdata == '0 && !resp_v_q))
    else $error("clear sweep overlaps a probe");

  a_no_take_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> !take_o)
    else $error("item taken during initial clear");

  a_resp_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_v_q |-> $past(state_q == ST_PROBE))
    else $error("memory response without a probe issue");

endmodule

// ===== sv/bloom_filter_murmur3_four_probe.sv =====
// Bloom filter over 64-bit keys with four MurmurHash3 x64_128 (seed 1) probes per key.
// Each key passes a 20-stage stalling hash pipeline (six 64-bit multiplies as 32x32
// partial products, then a 4-bit-per-stage modulo by FilterBits), then the probe engine
// makes four accesses to one row-organized bit memory, one probe after another through
// its single read port; the next insert or query is taken as the last probe issues.
// A clear sweeps the memory one 32-bit row per cycle, and after reset the same sweep
// runs with in_ready_o low. Any FilterBits from 64 upward works, power of two or not.
module bloom_filter_murmur3_four_probe import bfm_pkg::*; #(
  parameter int unsigned FilterBits = FILTER_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [63:0] key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        maybe_present_o
);

  localparam int unsigned IdxW = $clog2(FilterBits);

  logic    hash_en, busy, take;
  bfm_op_t hop;
  logic [NUM_PROBES-1:0][IdxW-1:0] hidx;

  assign in_ready_o = hash_en && !busy;

  bfm_hash #(.FilterBits(FilterBits)) u_hash (
    .clk_i,
    .rst_ni,
    .in_vld_i(in_valid_i && !busy),
    .func_i,
    .key_i,
    .en_o    (hash_en),
    .op_o    (hop),
    .idx_o   (hidx),
    .take_i  (take)
  );

  bfm_probe #(.FilterBits(FilterBits)) u_probe (
    .clk_i,
    .rst_ni,
    .op_i           (hop),
    .idx_i          (hidx),
    .take_o         (take),
    .busy_o         (busy),
    .out_valid_o,
    .out_ready_i,
    .maybe_present_o
  );

endmodule
